@@ hw/rtl/msp_pkg.sv @@
// Shared types and constants for the multichannel solenoid PWM block.
package msp_pkg;

    // Beat kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_DUTY = 2'd1,
        KIND_SPOT     = 2'd2,
        KIND_ALL_OFF  = 2'd3
    } kind_t;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int CHANNEL_MAX      = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CH_W      = 4;
    localparam int DUTY_W    = 7;
    localparam int TICK_W    = 8;
    localparam int PROD_W    = 15;  // 99 * 255 fits in 15 bits
    localparam int PIN_OUT_W = 4;   // channels shown on the result beat
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    localparam logic [TICK_W-1:0] PERIOD_RESET = 8'd50;
    localparam logic [DUTY_W-1:0] DUTY_MAX     = 7'd99;
    localparam logic [TICK_W-1:0] COUNT_MAX    = 8'hFF;

    // floor(x / 100) = (x * 5243) >> 19 for every x below 2^15
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int              RECIP_SHIFT = 19;
    localparam int              QUOT_W      = PROD_W + RECIP_W;

    // Decoded beat held in the front stage
    typedef struct packed {
        kind_t               kind;
        logic [CH_W-1:0]     channel;
        logic                rejected;
        logic [DUTY_W-1:0]   duty;
        logic                level;
        logic [PROD_W-1:0]   product;
    } front_t;

    // Command handed from front to back through the queue
    typedef struct packed {
        kind_t               kind;
        logic [CH_W-1:0]     channel;
        logic                rejected;
        logic [DUTY_W-1:0]   duty;
        logic                level;
        logic [TICK_W-1:0]   high;
        logic [TICK_W-1:0]   low;
    } cmd_t;

endpackage

@@ hw/rtl/msp_front.sv @@
// Front end: accepts input beats, decodes them and works out the phase lengths.
module msp_front #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic [msp_pkg::TICK_W-1:0]    period,
    output logic                          push_valid,
    input  logic                          push_ready,
    output msp_pkg::cmd_t                 push_data
);

    logic              f_valid_reg, f_valid_next;
    msp_pkg::front_t   f_stage_reg, f_stage_next;
    msp_pkg::kind_t    in_kind;
    logic [msp_pkg::CH_W-1:0]   in_channel;
    logic [msp_pkg::DUTY_W-1:0] in_duty, duty_sat;
    logic              in_level;
    logic              out_of_range;
    logic [msp_pkg::QUOT_W-1:0] quot;
    logic [msp_pkg::TICK_W-1:0] high_ticks;

    assign in_kind    = msp_pkg::kind_t'(s_tuser);
    assign in_channel = s_tdata[3:0];
    assign in_duty    = s_tdata[10:4];
    assign in_level   = s_tdata[11];

    // Stage is free, or it drains into the queue this cycle
    assign s_tready   = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;

    // Decode: range check, duty clamp, duty * period
    always_comb begin
        out_of_range = {1'b0, in_channel} >= 5'(CHANNELS);
        duty_sat     = (in_duty > msp_pkg::DUTY_MAX) ? msp_pkg::DUTY_MAX : in_duty;

        f_stage_next          = f_stage_reg;
        f_stage_next.kind     = in_kind;
        f_stage_next.channel  = in_channel;
        f_stage_next.duty     = duty_sat;
        f_stage_next.level    = in_level;
        f_stage_next.product  = msp_pkg::PROD_W'(duty_sat * period);
        f_stage_next.rejected = out_of_range &&
            (in_kind == msp_pkg::KIND_SET_DUTY || in_kind == msp_pkg::KIND_SPOT);

        f_valid_next = f_valid_reg;
        if (s_tvalid && s_tready)
            f_valid_next = 1'b1;
        else if (push_ready)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            f_stage_reg <= f_stage_next;
    end

    // Divide by 100 through the reciprocal
    assign quot       = msp_pkg::QUOT_W'(f_stage_reg.product * msp_pkg::RECIP_100);
    assign high_ticks = msp_pkg::TICK_W'(quot >> msp_pkg::RECIP_SHIFT);

    always_comb begin
        push_data.kind     = f_stage_reg.kind;
        push_data.channel  = f_stage_reg.channel;
        push_data.rejected = f_stage_reg.rejected;
        push_data.duty     = f_stage_reg.duty;
        push_data.level    = f_stage_reg.level;
        push_data.high     = high_ticks;
        push_data.low      = period - high_ticks;
    end

endmodule

@@ hw/rtl/msp_queue.sv @@
// Short command queue between the front end and the channel engine.
module msp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  msp_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output msp_pkg::cmd_t  pop_data,
    output logic           empty
);

    localparam int Depth = msp_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    msp_pkg::cmd_t     mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign full     = count_reg == CntW'(Depth);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hw/rtl/msp_engine.sv @@
// Channel engine: per-channel PWM state, pin register and the result beat.
module msp_engine #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  msp_pkg::cmd_t                 q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msp_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int PinW = (CHANNELS > msp_pkg::PIN_OUT_W) ? CHANNELS : msp_pkg::PIN_OUT_W;

    logic [msp_pkg::DUTY_W-1:0] duty_reg    [CHANNELS];
    logic [msp_pkg::DUTY_W-1:0] duty_next   [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] high_reg    [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] high_next   [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] low_reg     [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] low_next    [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] elapsed_reg [CHANNELS];
    logic [msp_pkg::TICK_W-1:0] elapsed_next[CHANNELS];
    logic [msp_pkg::TICK_W-1:0] inc_cnt     [CHANNELS];
    logic [CHANNELS-1:0]        phase_reg, phase_next;
    logic [CHANNELS-1:0]        pins_reg, pins_next;
    logic [PinW-1:0]            pins_wide;
    logic                       m_valid_reg, m_valid_next;
    logic [msp_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // Take a command when the result register is free or drains now
    assign q_pop    = !q_empty && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Saturating count for a tick
    always_comb begin
        for (int n = 0; n < CHANNELS; n++)
            inc_cnt[n] = (elapsed_reg[n] == msp_pkg::COUNT_MAX) ? elapsed_reg[n]
                                                                 : elapsed_reg[n] + 1'b1;
    end

    // Apply one command to the channel it names, or to every channel for tick or all-off
    always_comb begin
        duty_next    = duty_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        pins_next    = pins_reg;
        if (q_pop) begin
            case (q_data.kind)
                msp_pkg::KIND_TICK: begin
                    for (int n = 0; n < CHANNELS; n++) begin
                        if (duty_reg[n] != '0) begin
                            if (inc_cnt[n] >= (phase_reg[n] ? high_reg[n] : low_reg[n])) begin
                                phase_next[n]   = ~phase_reg[n];
                                pins_next[n]    = ~phase_reg[n];
                                elapsed_next[n] = '0;
                            end else begin
                                elapsed_next[n] = inc_cnt[n];
                            end
                        end
                    end
                end
                msp_pkg::KIND_SET_DUTY: begin
                    for (int n = 0; n < CHANNELS; n++) begin
                        if (!q_data.rejected && q_data.channel == msp_pkg::CH_W'(n)) begin
                            duty_next[n] = q_data.duty;
                            high_next[n] = q_data.high;
                            low_next[n]  = q_data.low;
                            if (q_data.duty == '0)
                                pins_next[n] = 1'b0;
                        end
                    end
                end
                msp_pkg::KIND_SPOT: begin
                    for (int n = 0; n < CHANNELS; n++) begin
                        if (!q_data.rejected && q_data.channel == msp_pkg::CH_W'(n))
                            pins_next[n] = q_data.level;
                    end
                end
                msp_pkg::KIND_ALL_OFF: begin
                    pins_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result beat: pin levels in the low bits, reject flag above
    always_comb begin
        pins_wide    = PinW'(pins_next);
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
            m_data_next  = msp_pkg::M_DATA_W'({q_data.rejected,
                                               pins_wide[msp_pkg::PIN_OUT_W-1:0]});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < CHANNELS; n++) begin
                duty_reg[n]    <= '0;
                high_reg[n]    <= '0;
                low_reg[n]     <= '0;
                elapsed_reg[n] <= '0;
            end
            phase_reg   <= '0;
            pins_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            duty_reg    <= duty_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            pins_reg    <= pins_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop)
            m_data_reg <= m_data_next;
    end

endmodule

@@ hw/rtl/multichannel_solenoid_pwm.sv @@
// Top level of the multichannel solenoid PWM: front end, command queue, channel engine.
//
//  channel  | direction | tdata (low bit up)                  | tuser
//  s_       | in        | channel[3:0] duty[10:4] level[11]   | kind[1:0]
//  m_       | out       | pin_levels[3:0] rejected[4]         | -
//  cfg_wr_  | in        | period_ms[7:0]                      | -
//
// One beat is accepted per cycle when the output side keeps up.
// From input beat to result beat, the front stage registers the decode and
// duty * period multiply, the reciprocal divide by 100 feeds the queue, then the
// channel engine updates state and loads the output register.
// The four-entry queue absorbs output stalls; s_tready drops only once it fills.
// Synchronous active-low reset clears all channel state; period_ms resets to 50.
module multichannel_solenoid_pwm #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msp_pkg::S_DATA_W-1:0]  s_tdata,   // channel, duty, level, zero pad
    input  logic [1:0]                    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msp_pkg::M_DATA_W-1:0]  m_tdata,   // pin_levels, rejected, zero pad
    input  logic                          cfg_wr_en,
    input  logic [msp_pkg::TICK_W-1:0]    cfg_wr_data
);

    logic [msp_pkg::TICK_W-1:0] period_reg;
    logic                       push_valid, q_push, q_full, q_empty, q_pop;
    msp_pkg::cmd_t              push_data, pop_data;

    // Period register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= msp_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    assign q_push = push_valid && !q_full;

    msp_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .period     (period_reg),
        .push_valid (push_valid),
        .push_ready (!q_full),
        .push_data  (push_data)
    );

    msp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    msp_engine #(.CHANNELS(CHANNELS)) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // Queue never reports full and empty together
    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

    // A stalled result is never overwritten by a new command
    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("command taken while result stalled");

    // A new beat enters only when the front stage is empty or draining
    a_front_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!push_valid || q_push))
        else $error("front stage overwritten");

    // Every command taken by the engine shows up as a result beat
    a_pop_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid)
        else $error("result beat missing after command");
`endif

endmodule
